// ----- src/lssc_pkg.sv -----
// Shared types, constants and helper functions of the line segment screen clipper.
package lssc_pkg;

   localparam int SCREEN_WIDTH_DEF  = 1920;
   localparam int SCREEN_HEIGHT_DEF = 1080;

   localparam int COORD_W = 32;
   localparam int HALF_W  = 32;
   localparam int DELTA_W = 33;
   localparam int DEPTH_W = 24;
   localparam int FRAC_W  = 8;
   localparam int NUM_W   = 64;
   localparam int DEN1_W  = DELTA_W + FRAC_W;

   localparam logic signed [NUM_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [NUM_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

   typedef struct packed {
      logic                      vis;
      logic                      in0;
      logic                      vert;
      logic                      horz;
      logic                      x_hi;
      logic                      x_lo;
      logic                      y_hi;
      logic                      y_lo;
      logic signed [COORD_W-1:0] rx;
      logic signed [COORD_W-1:0] ry;
      logic signed [DEPTH_W-1:0] cz;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
      logic signed [NUM_W-1:0]   dyw;
      logic signed [NUM_W-1:0]   hdx;
      logic signed [NUM_W-1:0]   yi;
   } item_type;

   // Rounds a fixed-point value to an integer, halves away from zero.
   function automatic logic signed [COORD_W-1:0] rnd_frac(input logic signed [COORD_W-1:0] v);
      logic [COORD_W:0] mag;
      logic [COORD_W:0] q;
      mag = v[COORD_W-1] ? ((COORD_W+1)'(0) - {v[COORD_W-1], v}) : {1'b0, v};
      q   = (mag + (COORD_W+1)'(2 ** (FRAC_W - 1))) >> FRAC_W;
      if (v[COORD_W-1]) begin
         q = (COORD_W+1)'(0) - q;
      end
      return q[COORD_W-1:0];
   endfunction

   // Clamps a wide signed value to the 32-bit signed range.
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [NUM_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[COORD_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- src/lssc_if.sv -----
// Valid/ready channel interfaces for segment words and result words.
interface lssc_req_if import lssc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] start_x;
   logic signed [COORD_W-1:0] start_y;
   logic signed [COORD_W-1:0] start_z;
   logic signed [COORD_W-1:0] end_x_in;
   logic signed [COORD_W-1:0] end_y_in;
   logic signed [COORD_W-1:0] end_z_in;

   modport source (output valid, output start_x, output start_y, output start_z,
                   output end_x_in, output end_y_in, output end_z_in, input ready);
   modport sink (input valid, input start_x, input start_y, input start_z,
                 input end_x_in, input end_y_in, input end_z_in, output ready);
endinterface

interface lssc_rsp_if import lssc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      visible;
   logic signed [COORD_W-1:0] clip_x;
   logic signed [COORD_W-1:0] clip_y;
   logic signed [DEPTH_W-1:0] clip_z;

   modport source (output valid, output visible, output clip_x, output clip_y,
                   output clip_z, input ready);
   modport sink (input valid, input visible, input clip_x, input clip_y,
                 input clip_z, output ready);
endinterface

// ----- src/lssc_front.sv -----
// Front stages: cross products, region flags, depth, rounding and the visibility test.
module lssc_front import lssc_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] x0,
   input  logic signed [COORD_W-1:0] y0,
   input  logic signed [COORD_W-1:0] z0,
   input  logic signed [COORD_W-1:0] x1,
   input  logic signed [COORD_W-1:0] y1,
   input  logic signed [COORD_W-1:0] z1,
   output logic                      out_valid,
   output item_type                  out_item,
   output logic signed [NUM_W-1:0]   out_num,
   output logic signed [DEN1_W-1:0]  out_den
);

   localparam logic signed [NUM_W-1:0] W64 = NUM_W'(SCREEN_WIDTH);
   localparam logic signed [NUM_W-1:0] H64 = NUM_W'(SCREEN_HEIGHT);
   localparam logic signed [NUM_W-1:0] W8  = NUM_W'(SCREEN_WIDTH * (2 ** FRAC_W));
   localparam logic signed [NUM_W-1:0] H8  = NUM_W'(SCREEN_HEIGHT * (2 ** FRAC_W));

   logic signed [NUM_W-1:0]   x0e, y0e, x1e, y1e;
   logic signed [COORD_W-1:0] zmax;
   logic signed [DELTA_W-1:0] zadj;
   logic                      in1;
   logic signed [NUM_W-1:0]   a_c, h8dx_c;
   logic                      same_c, lt_c, gt_c, dpos_c;

   logic                    s1_valid_ff, s1_valid_in;
   item_type                s1_item_ff, s1_item_in;
   logic                    s1_in01_ff, s1_in01_in;
   logic                    s1_rej_ff, s1_rej_in;
   logic signed [NUM_W-1:0] s1_pa_ff, s1_pa_in;
   logic signed [NUM_W-1:0] s1_pb_ff, s1_pb_in;

   logic                    s2_valid_ff, s2_valid_in;
   item_type                s2_item_ff, s2_item_in;
   logic                    s2_in01_ff, s2_in01_in;
   logic                    s2_rej_ff, s2_rej_in;
   logic signed [NUM_W-1:0] s2_n_ff, s2_n_in;
   logic signed [NUM_W-1:0] s2_m1_ff, s2_m1_in;
   logic signed [NUM_W-1:0] s2_m2_ff, s2_m2_in;

   logic                    s3_valid_ff, s3_valid_in;
   item_type                s3_item_ff, s3_item_in;
   logic signed [NUM_W-1:0] s3_n_ff, s3_n_in;

   always_comb begin
      x0e  = NUM_W'(x0);
      y0e  = NUM_W'(y0);
      x1e  = NUM_W'(x1);
      y1e  = NUM_W'(y1);
      zmax = (z0 >= z1) ? z0 : z1;
      zadj = DELTA_W'(zmax) + (zmax[COORD_W-1] ? DELTA_W'(2 ** FRAC_W - 1) : '0);
      in1  = (x1e >= 0) && (x1e < W8) && (y1e >= 0) && (y1e < H8);

      s1_item_in      = '0;
      s1_item_in.x_hi = x0e >= W8;
      s1_item_in.x_lo = x0[COORD_W-1];
      s1_item_in.y_hi = y0e >= H8;
      s1_item_in.y_lo = y0[COORD_W-1];
      s1_item_in.in0  = (x0e >= 0) && (x0e < W8) && (y0e >= 0) && (y0e < H8);
      s1_item_in.dx   = DELTA_W'(x1) - DELTA_W'(x0);
      s1_item_in.dy   = DELTA_W'(y1) - DELTA_W'(y0);
      s1_item_in.vert = s1_item_in.dx == '0;
      s1_item_in.horz = s1_item_in.dy == '0;
      s1_item_in.rx   = rnd_frac(x0);
      s1_item_in.ry   = rnd_frac(y0);
      s1_item_in.cz   = zadj[FRAC_W +: DEPTH_W];
      s1_item_in.dyw  = NUM_W'(s1_item_in.dy) * W64;
      s1_item_in.hdx  = NUM_W'(s1_item_in.dx) * H64;
      s1_in01_in      = s1_item_in.in0 || in1;
      s1_rej_in       = (x0[COORD_W-1] && x1[COORD_W-1])
                        || ((x0e >= W8) && (x1e >= W8))
                        || (y0[COORD_W-1] && y1[COORD_W-1])
                        || ((y0e >= H8) && (y1e >= H8));
      s1_pa_in        = y0e * x1e;
      s1_pb_in        = y1e * x0e;
      s1_valid_in     = in_valid;

      a_c         = s1_item_ff.dyw <<< FRAC_W;
      h8dx_c      = s1_item_ff.hdx <<< FRAC_W;
      same_c      = s1_item_ff.dy[DELTA_W-1] == s1_item_ff.dx[DELTA_W-1];
      s2_item_in  = s1_item_ff;
      s2_in01_in  = s1_in01_ff;
      s2_rej_in   = s1_rej_ff;
      s2_n_in     = s1_pa_ff - s1_pb_ff;
      s2_m1_in    = same_c ? h8dx_c : (h8dx_c - a_c);
      s2_m2_in    = same_c ? -a_c : '0;
      s2_valid_in = s1_valid_ff;

      dpos_c = !s2_item_ff.dx[DELTA_W-1];
      lt_c   = dpos_c ? (s2_n_ff < s2_m1_ff) : (s2_n_ff > s2_m1_ff);
      gt_c   = dpos_c ? (s2_n_ff > s2_m2_ff) : (s2_n_ff < s2_m2_ff);
      s3_item_in = s2_item_ff;
      if (s2_in01_ff) begin
         s3_item_in.vis = 1'b1;
      end else if (s2_rej_ff) begin
         s3_item_in.vis = 1'b0;
      end else if (s2_item_ff.vert) begin
         s3_item_in.vis = !s2_item_ff.x_lo && !s2_item_ff.x_hi;
      end else if (s2_item_ff.horz) begin
         s3_item_in.vis = !s2_item_ff.y_lo && !s2_item_ff.y_hi;
      end else begin
         s3_item_in.vis = lt_c && gt_c;
      end
      s3_n_in     = s2_n_ff;
      s3_valid_in = s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
      if (en) begin
         s1_item_ff <= s1_item_in;
         s1_in01_ff <= s1_in01_in;
         s1_rej_ff  <= s1_rej_in;
         s1_pa_ff   <= s1_pa_in;
         s1_pb_ff   <= s1_pb_in;
         s2_item_ff <= s2_item_in;
         s2_in01_ff <= s2_in01_in;
         s2_rej_ff  <= s2_rej_in;
         s2_n_ff    <= s2_n_in;
         s2_m1_ff   <= s2_m1_in;
         s2_m2_ff   <= s2_m2_in;
         s3_item_ff <= s3_item_in;
         s3_n_ff    <= s3_n_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;
   assign out_num   = s3_n_ff;
   assign out_den   = $signed({s3_item_ff.dx, {FRAC_W{1'b0}}});

endmodule

// ----- src/lssc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, rounding half away from zero.
module lssc_div import lssc_pkg::*; #(
   parameter int DEN_W  = DELTA_W,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [NUM_W-1:0] in_num,
   input  logic signed [DEN_W-1:0] in_den,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic signed [NUM_W-1:0] out_quo,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int STEPS = NUM_W;
   localparam logic [NUM_W:0] QUO_MAX = {2'b00, {(NUM_W-1){1'b1}}};

   logic              valid_ff [0:STEPS];
   logic              valid_in [0:STEPS];
   logic [NUM_W-1:0]  nq_ff    [0:STEPS];
   logic [NUM_W-1:0]  nq_in    [0:STEPS];
   logic [DEN_W-1:0]  rem_ff   [0:STEPS];
   logic [DEN_W-1:0]  rem_in   [0:STEPS];
   logic [DEN_W-1:0]  ad_ff    [0:STEPS];
   logic [DEN_W-1:0]  ad_in    [0:STEPS];
   logic              neg_ff   [0:STEPS];
   logic              neg_in   [0:STEPS];
   logic [SIDE_W-1:0] side_ff  [0:STEPS];
   logic [SIDE_W-1:0] side_in  [0:STEPS];
   logic [DEN_W:0]    rsh      [1:STEPS];
   logic              ge       [1:STEPS];

   logic                    rnd;
   logic [NUM_W:0]          q1;
   logic [NUM_W-1:0]        qs;
   logic                    ovalid_ff, ovalid_in;
   logic signed [NUM_W-1:0] quo_ff, quo_in;
   logic [SIDE_W-1:0]       oside_ff, oside_in;

   always_comb begin
      valid_in[0] = in_valid;
      nq_in[0]    = in_num[NUM_W-1] ? -in_num : in_num;
      ad_in[0]    = in_den[DEN_W-1] ? -in_den : in_den;
      rem_in[0]   = '0;
      neg_in[0]   = in_num[NUM_W-1] ^ in_den[DEN_W-1];
      side_in[0]  = in_side;
      for (int k = 1; k <= STEPS; k++) begin
         rsh[k]      = {rem_ff[k-1], nq_ff[k-1][NUM_W-1]};
         ge[k]       = rsh[k] >= {1'b0, ad_ff[k-1]};
         rem_in[k]   = ge[k] ? DEN_W'(rsh[k] - {1'b0, ad_ff[k-1]}) : rsh[k][DEN_W-1:0];
         nq_in[k]    = {nq_ff[k-1][NUM_W-2:0], ge[k]};
         ad_in[k]    = ad_ff[k-1];
         neg_in[k]   = neg_ff[k-1];
         side_in[k]  = side_ff[k-1];
         valid_in[k] = valid_ff[k-1];
      end

      rnd = {rem_ff[STEPS], 1'b0} >= {1'b0, ad_ff[STEPS]};
      q1  = {1'b0, nq_ff[STEPS]} + (NUM_W+1)'(rnd);
      qs  = (q1 > QUO_MAX) ? QUO_MAX[NUM_W-1:0] : q1[NUM_W-1:0];
      if (ad_ff[STEPS] == '0) begin
         quo_in = '0;
      end else if (neg_ff[STEPS]) begin
         quo_in = -$signed(qs);
      end else begin
         quo_in = $signed(qs);
      end
      oside_in  = side_ff[STEPS];
      ovalid_in = valid_ff[STEPS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STEPS; k++) begin
            valid_ff[k] <= 1'b0;
         end
         ovalid_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k <= STEPS; k++) begin
            valid_ff[k] <= valid_in[k];
         end
         ovalid_ff <= ovalid_in;
      end
      if (en) begin
         for (int k = 0; k <= STEPS; k++) begin
            nq_ff[k]   <= nq_in[k];
            rem_ff[k]  <= rem_in[k];
            ad_ff[k]   <= ad_in[k];
            neg_ff[k]  <= neg_in[k];
            side_ff[k] <= side_in[k];
         end
         quo_ff   <= quo_in;
         oside_ff <= oside_in;
      end
   end

   assign out_valid = ovalid_ff;
   assign out_quo   = quo_ff;
   assign out_side  = oside_ff;

endmodule

// ----- src/lssc_mul.sv -----
// Wrapping 64-bit intercept product from 32-bit partial products, and the two dividends.
module lssc_mul import lssc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  item_type                in_item,
   input  logic signed [NUM_W-1:0] in_yi,
   output logic                    out_valid,
   output item_type                out_item,
   output logic signed [NUM_W-1:0] out_num2,
   output logic signed [NUM_W-1:0] out_num3
);

   logic [NUM_W-1:0]  dxe;
   logic [HALF_W-1:0] yl, yh, dl, dh;

   logic              m1_valid_ff, m1_valid_in;
   item_type          m1_item_ff, m1_item_in;
   logic [NUM_W-1:0]  m1_pp0_ff, m1_pp0_in;
   logic [HALF_W-1:0] m1_pp1_ff, m1_pp1_in;
   logic [HALF_W-1:0] m1_pp2_ff, m1_pp2_in;

   logic              m2_valid_ff, m2_valid_in;
   item_type          m2_item_ff, m2_item_in;
   logic [NUM_W-1:0]  m2_p_ff, m2_p_in;

   logic                    m3_valid_ff, m3_valid_in;
   item_type                m3_item_ff, m3_item_in;
   logic signed [NUM_W-1:0] m3_num2_ff, m3_num2_in;
   logic signed [NUM_W-1:0] m3_num3_ff, m3_num3_in;

   always_comb begin
      dxe = NUM_W'(in_item.dx);
      yl  = in_yi[HALF_W-1:0];
      yh  = in_yi[NUM_W-1:HALF_W];
      dl  = dxe[HALF_W-1:0];
      dh  = dxe[NUM_W-1:HALF_W];

      m1_item_in    = in_item;
      m1_item_in.yi = in_yi;
      m1_pp0_in     = NUM_W'(yl) * NUM_W'(dl);
      m1_pp1_in     = yl * dh;
      m1_pp2_in     = yh * dl;
      m1_valid_in   = in_valid;

      m2_item_in  = m1_item_ff;
      m2_p_in     = m1_pp0_ff + {m1_pp1_ff + m1_pp2_ff, {HALF_W{1'b0}}};
      m2_valid_in = m1_valid_ff;

      m3_item_in  = m2_item_ff;
      m3_num2_in  = m2_item_ff.dyw + $signed(m2_p_ff);
      m3_num3_in  = m2_item_ff.y_hi ? (m2_item_ff.hdx - $signed(m2_p_ff)) : $signed(m2_p_ff);
      m3_valid_in = m2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= m1_valid_in;
         m2_valid_ff <= m2_valid_in;
         m3_valid_ff <= m3_valid_in;
      end
      if (en) begin
         m1_item_ff <= m1_item_in;
         m1_pp0_ff  <= m1_pp0_in;
         m1_pp1_ff  <= m1_pp1_in;
         m1_pp2_ff  <= m1_pp2_in;
         m2_item_ff <= m2_item_in;
         m2_p_ff    <= m2_p_in;
         m3_item_ff <= m3_item_in;
         m3_num2_ff <= m3_num2_in;
         m3_num3_ff <= m3_num3_in;
      end
   end

   assign out_valid = m3_valid_ff;
   assign out_item  = m3_item_ff;
   assign out_num2  = m3_num2_ff;
   assign out_num3  = m3_num3_ff;

endmodule

// ----- src/line_segment_screen_clipper.sv -----
// Top level of the line segment screen clipper: pipeline assembly and the clipped point select.
//
//   channel   direction  words
//   req_chan  in         one segment: two endpoints x, y, z
//   rsp_chan  out        visible flag, clipped x and y, depth
//
// One word enters per cycle while the pipeline is not held. A word passes the front, a divider,
// the multiplier and two parallel dividers, all of 66 stages with 64 giving one quotient bit each.
// Reset clears only the valid bits of the stages.
// When a result waits on rsp_chan, the whole pipeline holds and req_chan.ready drops.
module line_segment_screen_clipper import lssc_pkg::*; #(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input logic         clock,
   input logic         reset,
   lssc_req_if.sink    req_chan,
   lssc_rsp_if.source  rsp_chan
);

   localparam logic signed [NUM_W-1:0] W64 = NUM_W'(SCREEN_WIDTH);
   localparam logic signed [NUM_W-1:0] H64 = NUM_W'(SCREEN_HEIGHT);

   logic                    en;
   logic                    f_valid;
   item_type                f_item;
   logic signed [NUM_W-1:0] f_num;
   logic signed [DEN1_W-1:0] f_den;
   logic                    d1_valid;
   logic signed [NUM_W-1:0] d1_quo;
   item_type                d1_item;
   logic                    m_valid;
   item_type                m_item;
   logic signed [NUM_W-1:0] m_num2, m_num3;
   logic                    d2_valid, d3_valid;
   logic signed [NUM_W-1:0] d2_quo, d3_quo;
   item_type                d2_item;
   logic                    d3_neg;

   logic signed [NUM_W-1:0] cx64, cy64;
   logic                    edge_hit;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      vis_ff, vis_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic signed [DEPTH_W-1:0] cz_ff, cz_in;

   assign en             = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   lssc_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .x0        (req_chan.start_x),
      .y0        (req_chan.start_y),
      .z0        (req_chan.start_z),
      .x1        (req_chan.end_x_in),
      .y1        (req_chan.end_y_in),
      .z1        (req_chan.end_z_in),
      .out_valid (f_valid),
      .out_item  (f_item),
      .out_num   (f_num),
      .out_den   (f_den)
   );

   lssc_div #(
      .DEN_W  (DEN1_W),
      .SIDE_W ($bits(item_type))
   ) u_div_yi (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_side   (f_item),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_side  (d1_item)
   );

   lssc_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d1_valid),
      .in_item   (d1_item),
      .in_yi     (d1_quo),
      .out_valid (m_valid),
      .out_item  (m_item),
      .out_num2  (m_num2),
      .out_num3  (m_num3)
   );

   lssc_div #(
      .DEN_W  (DELTA_W),
      .SIDE_W ($bits(item_type))
   ) u_div_wi (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid),
      .in_num    (m_num2),
      .in_den    (m_item.dx),
      .in_side   (m_item),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_side  (d2_item)
   );

   lssc_div #(
      .DEN_W  (DELTA_W),
      .SIDE_W (1)
   ) u_div_cx (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid),
      .in_num    (m_num3),
      .in_den    (m_item.dy),
      .in_side   (m_item.y_lo),
      .out_valid (d3_valid),
      .out_quo   (d3_quo),
      .out_side  (d3_neg)
   );

   always_comb begin
      edge_hit = (d2_item.x_hi && (d2_quo >= 0) && (d2_quo < H64))
                 || (d2_item.x_lo && (d2_item.yi >= 0) && (d2_item.yi < H64));
      if (d2_item.in0) begin
         cx64 = NUM_W'(d2_item.rx);
         cy64 = NUM_W'(d2_item.ry);
      end else if (d2_item.vert) begin
         cx64 = NUM_W'(d2_item.rx);
         cy64 = d2_item.y_hi ? (H64 - 1) : '0;
      end else if (d2_item.horz) begin
         cx64 = d2_item.x_hi ? (W64 - 1) : '0;
         cy64 = NUM_W'(d2_item.ry);
      end else if (edge_hit) begin
         cx64 = d2_item.x_hi ? (W64 - 1) : '0;
         cy64 = d2_item.x_hi ? d2_quo : d2_item.yi;
      end else begin
         cy64 = d2_item.y_hi ? (H64 - 1) : '0;
         if (d2_item.y_hi) begin
            cx64 = d3_quo;
         end else if (d3_neg) begin
            cx64 = -d3_quo;
         end else begin
            cx64 = '0;
         end
      end
      rsp_valid_in = d2_valid && d3_valid;
      vis_in       = d2_item.vis;
      cx_in        = sat_coord(cx64);
      cy_in        = sat_coord(cy64);
      cz_in        = d2_item.cz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (en) begin
         vis_ff <= vis_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         cz_ff  <= cz_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.visible = vis_ff;
   assign rsp_chan.clip_x  = cx_ff;
   assign rsp_chan.clip_y  = cy_ff;
   assign rsp_chan.clip_z  = cz_ff;

`ifndef ASSERT_OFF
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      d2_valid == d3_valid)
      else $error("The two tail dividers disagree on which words are valid.");

   a_onscreen_start: assert property (@(posedge clock) disable iff (reset)
      (d2_valid && d2_item.in0) |-> (d2_item.vis && (d2_item.rx >= 0)
                                     && (NUM_W'(d2_item.rx) <= W64)))
      else $error("A segment that starts on screen lost its visibility or x range.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("A result word is offered right after reset.");
`endif

endmodule

// ----- test/line_segment_screen_clipper_tb.sv -----
// Self-checking testbench of the line segment screen clipper with random flow control.
module line_segment_screen_clipper_tb;
   import lssc_pkg::*;

   localparam int  W_PIX     = SCREEN_WIDTH_DEF;
   localparam int  H_PIX     = SCREEN_HEIGHT_DEF;
   localparam int  PIPE_LAT  = 139;
   localparam int  N_RANDOM  = 1530;
   localparam int  HOLD_LEN  = 400;

   typedef struct {
      logic signed [COORD_W-1:0] x0, y0, z0, x1, y1, z1;
   } segment_type;

   typedef struct {
      logic                      vis;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [DEPTH_W-1:0] cz;
   } clip_type;

   typedef struct {
      segment_type seg;
      bit          typed;
      clip_type    clip;
   } directed_row_type;

   logic      clock;
   logic      reset;
   int        error_count;
   bit        feed_done;
   int        words_sent;
   clip_type  pending_clips[$];

   lssc_req_if req_if();
   lssc_rsp_if rsp_if();

   line_segment_screen_clipper i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic longint round_div(longint n, longint d);
      longint unsigned an, ad, q, r;
      if (d == 0) begin
         return 0;
      end
      an = n < 0 ? 64'd0 - longint'(n) : n;
      ad = d < 0 ? 64'd0 - longint'(d) : d;
      q  = an / ad;
      r  = an % ad;
      if (r >= ad - r) begin
         q++;
      end
      if (q > 64'h7FFF_FFFF_FFFF_FFFF) begin
         q = 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic clip_type clip_segment(segment_type s);
      longint   w, h, w8, h8, x0, y0, z0, x1, y1, z1, dx, dy, n, a, yi, wi, cx, cy, zm;
      bit       in0, in1;
      clip_type c;
      w  = W_PIX;
      h  = H_PIX;
      w8 = w * 256;
      h8 = h * 256;
      x0 = s.x0; y0 = s.y0; z0 = s.z0;
      x1 = s.x1; y1 = s.y1; z1 = s.z1;
      dx = x1 - x0;
      dy = y1 - y0;
      n  = y0 * x1 - y1 * x0;
      in0 = x0 >= 0 && x0 < w8 && y0 >= 0 && y0 < h8;
      in1 = x1 >= 0 && x1 < w8 && y1 >= 0 && y1 < h8;
      if (in0 || in1) begin
         c.vis = 1'b1;
      end else if ((x0 < 0 && x1 < 0) || (x0 >= w8 && x1 >= w8)
                   || (y0 < 0 && y1 < 0) || (y0 >= h8 && y1 >= h8)) begin
         c.vis = 1'b0;
      end else if (dx == 0) begin
         c.vis = x0 >= 0 && x0 < w8;
      end else if (dy == 0) begin
         c.vis = y0 >= 0 && y0 < h8;
      end else begin
         a = dy * w8;
         if ((dy > 0) == (dx > 0)) begin
            c.vis = (dx > 0 ? n < h8 * dx : n > h8 * dx) && (dx > 0 ? n > -a : n < -a);
         end else begin
            c.vis = (dx > 0 ? n < h8 * dx - a : n > h8 * dx - a) && (dx > 0 ? n > 0 : n < 0);
         end
      end

      if (in0) begin
         cx = round_div(x0, 256);
         cy = round_div(y0, 256);
      end else if (dx == 0) begin
         cx = round_div(x0, 256);
         cy = y0 >= h8 ? h - 1 : 0;
      end else if (dy == 0) begin
         cx = x0 >= w8 ? w - 1 : 0;
         cy = round_div(y0, 256);
      end else begin
         yi = round_div(n, 256 * dx);
         wi = round_div(dy * w + yi * dx, dx);
         if ((x0 >= w8 && wi >= 0 && wi < h) || (x0 < 0 && yi >= 0 && yi < h)) begin
            cx = x0 >= w8 ? w - 1 : 0;
            cy = x0 >= w8 ? wi : yi;
         end else begin
            cy = y0 >= h8 ? h - 1 : 0;
            if (y0 >= h8) begin
               cx = round_div((h - yi) * dx, dy);
            end else if (y0 < 0) begin
               cx = -round_div(yi * dx, dy);
            end else begin
               cx = 0;
            end
         end
      end
      c.cx = clamp32(cx);
      c.cy = clamp32(cy);
      zm   = z0 >= z1 ? z0 : z1;
      zm   = zm >= 0 ? (zm >>> 8) : -((-zm) >>> 8);
      c.cz = zm[DEPTH_W-1:0];
      return c;
   endfunction

   function automatic segment_type mk_seg(int x0, int y0, int z0, int x1, int y1, int z1);
      segment_type s;
      s.x0 = x0; s.y0 = y0; s.z0 = z0;
      s.x1 = x1; s.y1 = y1; s.z1 = z1;
      return s;
   endfunction

   function automatic int near_coord();
      return int'($urandom_range(5000 * 256, 0)) - 1500 * 256;
   endfunction

   function automatic segment_type random_segment();
      segment_type s;
      int          pick;
      pick = $urandom_range(99, 0);
      s = mk_seg(near_coord(), near_coord(), $urandom, near_coord(), near_coord(), $urandom);
      if (pick < 15) begin
         s = mk_seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 22) begin
         s.x1 = s.x0;
      end else if (pick < 29) begin
         s.y1 = s.y0;
      end else if (pick < 34) begin
         s.x1 = s.x0 + int'($urandom_range(8, 0)) - 4;
         s.y1 = s.y0 + int'($urandom_range(8, 0)) - 4;
      end else if (pick < 40) begin
         s.x0 = $urandom_range(1, 0) ? 32'sh7FFF_FFFF - $urandom_range(300, 0)
                                     : 32'sh8000_0000 + $urandom_range(300, 0);
         s.y1 = $urandom_range(1, 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end else if (pick < 46) begin
         s.z0 = $urandom_range(1, 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         s.z1 = int'($urandom_range(1024, 0)) - 512;
      end
      return s;
   endfunction

   function automatic int idle_gap(int idx);
      int p;
      if ((idx / 150) % 4 == 1) begin
         return 0;
      end
      p = $urandom_range(99, 0);
      if (p < 65) begin
         return 0;
      end else if (p < 95) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 10);
   endfunction

   task automatic send_segment(segment_type s, bit typed, clip_type exp_clip, int idx);
      int gap;
      gap = idle_gap(idx);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.start_x  = s.x0;
      req_if.start_y  = s.y0;
      req_if.start_z  = s.z0;
      req_if.end_x_in = s.x1;
      req_if.end_y_in = s.y1;
      req_if.end_z_in = s.z1;
      do begin
         @(posedge clock);
      end while (!req_if.ready);
      pending_clips.push_back(typed ? exp_clip : clip_segment(s));
      words_sent++;
      @(negedge clock);
   endtask

   initial begin
      directed_row_type rows[$];
      segment_type      s;
      clip_type         none;
      none = '{1'b0, 0, 0, 0};
      rows = '{
         '{mk_seg(0, 0, 0, 0, 0, 0), 1, '{1'b1, 0, 0, 0}},
         '{mk_seg(128, 128, -128, 0, 0, -300), 1, '{1'b1, 1, 1, 0}},
         '{mk_seg(-128, -128, 0, -1, 300000, 0), 0, none},
         '{mk_seg(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF), 1, '{1'b0, 8388608, 1079, 8388607}},
         '{mk_seg(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000), 1, '{1'b0, -8388608, 0, -8388608}},
         '{mk_seg(100 * 256, -500 * 256, 0, 100 * 256, 2000 * 256, 0), 1, '{1'b1, 100, 0, 0}},
         '{mk_seg(-500 * 256, 50 * 256, 0, 3000 * 256, 50 * 256, 0), 1, '{1'b1, 0, 50, 0}},
         '{mk_seg(-100 * 256, -50 * 256, 5, 3000 * 256, 2000 * 256, 9), 0, none},
         '{mk_seg(-100 * 256, 2000 * 256, 0, 2500 * 256, -300 * 256, 0), 0, none},
         '{mk_seg(2500 * 256, 500 * 256, 0, -100 * 256, 400 * 256, 0), 0, none},
         '{mk_seg(500 * 256, 1500 * 256, 0, 900 * 256, -200 * 256, 0), 0, none},
         '{mk_seg(700 * 256, -300 * 256, 0, 1000 * 256, 1300 * 256, 0), 0, none},
         '{mk_seg(-500 * 256, 900 * 256, 0, 300 * 256, 1500 * 256, 0), 0, none},
         '{mk_seg(-20 * 256, 1100 * 256, 0, 40 * 256, -60 * 256, 0), 0, none},
         '{mk_seg(491520, 0, 0, 491520, 276480, 0), 0, none},
         '{mk_seg(491519, 276479, -384, 0, 0, -385), 1, '{1'b1, 1920, 1080, -1}},
         '{mk_seg(-128, 300, 383, 600000, -200, 128), 0, none},
         '{mk_seg(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0),
           0, none},
         '{mk_seg(32'sh8000_0000, 1, 0, 32'sh8000_0001, 32'sh7FFF_FFFF, 0), 0, none},
         '{mk_seg(3000 * 256, -900 * 256, 0, 2900 * 256, -899 * 256, 0), 0, none}
      };
      error_count     = 0;
      feed_done       = 1'b0;
      words_sent      = 0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.start_x  = '0;
      req_if.start_y  = '0;
      req_if.start_z  = '0;
      req_if.end_x_in = '0;
      req_if.end_y_in = '0;
      req_if.end_z_in = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (rows[i]) begin
         send_segment(rows[i].seg, rows[i].typed, rows[i].clip, i);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         s = random_segment();
         send_segment(s, 1'b0, none, i);
      end
      req_if.valid = 1'b0;
      feed_done    = 1'b1;
   end

   initial begin
      int  hold;
      bit  held;
      int  p;
      held = 1'b0;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && words_sent >= 300) begin
            held = 1'b1;
            rsp_if.ready = 1'b0;
            for (hold = 0; hold < HOLD_LEN; hold++) @(negedge clock);
         end
         p = $urandom_range(99, 0);
         if ((words_sent / 200) % 3 == 2 || p < 70) begin
            rsp_if.ready = 1'b1;
         end else begin
            rsp_if.ready = 1'b0;
            if (p >= 97) begin
               repeat ($urandom_range(40, 10)) @(negedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      clip_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_clips.size() == 0) begin
            $display("%0t: result word with no expectation waiting", $time);
            error_count++;
         end else begin
            e = pending_clips.pop_front();
            if (rsp_if.visible !== e.vis) begin
               $display("%0t: visible expected %0d actual %0d", $time, e.vis, rsp_if.visible);
               error_count++;
            end
            if (rsp_if.clip_x !== e.cx) begin
               $display("%0t: clip_x expected %0d actual %0d", $time, e.cx, rsp_if.clip_x);
               error_count++;
            end
            if (rsp_if.clip_y !== e.cy) begin
               $display("%0t: clip_y expected %0d actual %0d", $time, e.cy, rsp_if.clip_y);
               error_count++;
            end
            if (rsp_if.clip_z !== e.cz) begin
               $display("%0t: clip_z expected %0d actual %0d", $time, e.cz, rsp_if.clip_z);
               error_count++;
            end
         end
      end
   end

   initial begin
      wait (feed_done);
      while (pending_clips.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- line_segment_screen_clipper.f -----
src/lssc_pkg.sv
src/lssc_if.sv
src/lssc_front.sv
src/lssc_div.sv
src/lssc_mul.sv
src/line_segment_screen_clipper.sv
test/line_segment_screen_clipper_tb.sv
